// ===== rtl/core/hsvct_pkg.sv =====
// Shared types, constants and the pixel classifier for the HSV color class tally.
// Used by hsvct_ctrl, hsvct_datapath, hsv_color_class_tally and hsvct_checker.
`default_nettype none

package hsvct_pkg;

    // Counter and class sizing
    localparam int COUNT_WIDTH = 21;
    localparam int NUM_CLASSES = 11;
    localparam int CLASS_W     = $clog2(NUM_CLASSES);
    localparam int CONF_W      = 7;
    localparam int PROD_W      = COUNT_WIDTH + CONF_W;
    localparam int STEP_W      = $clog2(CONF_W);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
    localparam logic [CONF_W-1:0]      PCT_SCALE = CONF_W'(100);

    // Class codes
    localparam logic [CLASS_W-1:0] CLS_BLACK  = CLASS_W'(0);
    localparam logic [CLASS_W-1:0] CLS_WHITE  = CLASS_W'(1);
    localparam logic [CLASS_W-1:0] CLS_GREY   = CLASS_W'(2);
    localparam logic [CLASS_W-1:0] CLS_RED    = CLASS_W'(3);
    localparam logic [CLASS_W-1:0] CLS_ORANGE = CLASS_W'(4);
    localparam logic [CLASS_W-1:0] CLS_YELLOW = CLASS_W'(5);
    localparam logic [CLASS_W-1:0] CLS_GREEN  = CLASS_W'(6);
    localparam logic [CLASS_W-1:0] CLS_AQUA   = CLASS_W'(7);
    localparam logic [CLASS_W-1:0] CLS_BLUE   = CLASS_W'(8);
    localparam logic [CLASS_W-1:0] CLS_PURPLE = CLASS_W'(9);
    localparam logic [CLASS_W-1:0] CLS_PINK   = CLASS_W'(10);
    localparam logic [CLASS_W-1:0] CLS_LAST   = CLASS_W'(NUM_CLASSES - 1);

    // Achromatic thresholds
    localparam logic [7:0] BLACK_VAL_MAX = 8'd75;
    localparam logic [7:0] WHITE_VAL_MIN = 8'd190;
    localparam logic [7:0] WHITE_SAT_MAX = 8'd7;
    localparam logic [7:0] GREY_SAT_MAX  = 8'd53;
    localparam logic [7:0] GREY_VAL_MAX  = 8'd185;

    // Hue band upper bounds (exclusive)
    localparam logic [7:0] HUE_RED    = 8'd14;
    localparam logic [7:0] HUE_ORANGE = 8'd25;
    localparam logic [7:0] HUE_YELLOW = 8'd34;
    localparam logic [7:0] HUE_GREEN  = 8'd73;
    localparam logic [7:0] HUE_AQUA   = 8'd102;
    localparam logic [7:0] HUE_BLUE   = 8'd127;
    localparam logic [7:0] HUE_PURPLE = 8'd149;
    localparam logic [7:0] HUE_PINK   = 8'd175;

    // Input beat
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic       end_of_frame;
    } pixel_t;

    // Output beat
    typedef struct packed {
        logic [CLASS_W-1:0] color_class;
        logic               frame_done;
        logic [CLASS_W-1:0] dominant_class;
        logic [CONF_W-1:0]  confidence_pct;
    } result_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // pixel beat taken this cycle
        logic search_en;    // scan one class counter
        logic mult_en;      // form dominant count * 100
        logic div_en;       // one restoring divide step
        logic finish;       // push frame result, clear counters
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic res_free;     // result stage can take a beat
        logic search_last;  // scanning the last class
        logic div_last;     // last quotient bit
    } status_t;

    // Pixel classifier
    function automatic logic [CLASS_W-1:0] classify(input logic [7:0] h,
                                                    input logic [7:0] s,
                                                    input logic [7:0] v);
        logic [CLASS_W-1:0] c;
        if (v < BLACK_VAL_MAX) begin
            c = CLS_BLACK;
        end else if (v > WHITE_VAL_MIN && s < WHITE_SAT_MAX) begin
            c = CLS_WHITE;
        end else if (s < GREY_SAT_MAX && v < GREY_VAL_MAX) begin
            c = CLS_GREY;
        end else if (h < HUE_RED) begin
            c = CLS_RED;
        end else if (h < HUE_ORANGE) begin
            c = CLS_ORANGE;
        end else if (h < HUE_YELLOW) begin
            c = CLS_YELLOW;
        end else if (h < HUE_GREEN) begin
            c = CLS_GREEN;
        end else if (h < HUE_AQUA) begin
            c = CLS_AQUA;
        end else if (h < HUE_BLUE) begin
            c = CLS_BLUE;
        end else if (h < HUE_PURPLE) begin
            c = CLS_PURPLE;
        end else if (h < HUE_PINK) begin
            c = CLS_PINK;
        end else begin
            // top of the hue circle wraps to red
            c = CLS_RED;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hsvct_ctrl.sv =====
// Frame controller for the HSV color class tally: input handshake and the
// end-of-frame sequence (search, multiply, divide, report). Depends on hsvct_pkg.
`default_nettype none

module hsvct_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_eof,
    input  wire hsvct_pkg::status_t st,
    output logic                   s_ready,
    output hsvct_pkg::cmd_t        cmd
);

    hsvct_pkg::state_t state_reg;
    hsvct_pkg::state_t state_next;
    logic              accept;

    // Input beat taken only when idle and the result stage has room
    assign s_ready = (state_reg == hsvct_pkg::ST_IDLE) && st.res_free;
    assign accept  = s_valid && s_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hsvct_pkg::ST_IDLE: begin
                if (accept && s_eof) begin
                    state_next = hsvct_pkg::ST_SEARCH;
                end
            end
            hsvct_pkg::ST_SEARCH: begin
                if (st.search_last) begin
                    state_next = hsvct_pkg::ST_MULT;
                end
            end
            hsvct_pkg::ST_MULT: begin
                state_next = hsvct_pkg::ST_DIV;
            end
            hsvct_pkg::ST_DIV: begin
                if (st.div_last) begin
                    state_next = hsvct_pkg::ST_DONE;
                end
            end
            hsvct_pkg::ST_DONE: begin
                if (st.res_free) begin
                    state_next = hsvct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hsvct_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            hsvct_pkg::ST_IDLE:   cmd.accept    = accept;
            hsvct_pkg::ST_SEARCH: cmd.search_en = 1'b1;
            hsvct_pkg::ST_MULT:   cmd.mult_en   = 1'b1;
            hsvct_pkg::ST_DIV:    cmd.div_en    = 1'b1;
            hsvct_pkg::ST_DONE:   cmd.finish    = st.res_free;
            default:              cmd           = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hsvct_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hsvct_datapath.sv =====
// Datapath for the HSV color class tally: class counters, dominant search,
// percent multiply, restoring divider and the two-deep result buffer.
// Depends on hsvct_pkg.
`default_nettype none

module hsvct_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hsvct_pkg::cmd_t   cmd,
    input  wire hsvct_pkg::pixel_t s_data,
    input  wire logic              m_ready,
    output hsvct_pkg::status_t     st,
    output logic                   m_valid,
    output hsvct_pkg::result_t     m_data
);

    localparam int CW = hsvct_pkg::COUNT_WIDTH;
    localparam int KW = hsvct_pkg::CLASS_W;
    localparam int QW = hsvct_pkg::CONF_W;
    localparam int PW = hsvct_pkg::PROD_W;
    localparam int SW = hsvct_pkg::STEP_W;

    logic [CW-1:0] cnt_reg  [hsvct_pkg::NUM_CLASSES];
    logic [CW-1:0] cnt_next [hsvct_pkg::NUM_CLASSES];
    logic [CW-1:0] pix_reg,  pix_next;
    logic [KW-1:0] cls_new;
    logic [KW-1:0] cls_reg,  cls_next;

    logic [KW-1:0] idx_reg,  idx_next;
    logic [CW-1:0] best_reg, best_next;
    logic [KW-1:0] dom_reg,  dom_next;
    logic [CW-1:0] cur_cnt;

    logic [PW-1:0] rem_reg,  rem_next;
    logic [PW-1:0] dvs_reg,  dvs_next;
    logic [QW-1:0] quo_reg,  quo_next;
    logic [SW-1:0] step_reg, step_next;
    logic          fits;

    hsvct_pkg::result_t res_reg, res_next;
    hsvct_pkg::result_t out_reg, out_next;
    logic               res_valid_reg, res_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               res_move;
    logic               push;

    // Classify the incoming beat
    assign cls_new = hsvct_pkg::classify(s_data.hue, s_data.sat, s_data.val);

    // Saturating counters, cleared after the frame report
    always_comb begin
        for (int i = 0; i < hsvct_pkg::NUM_CLASSES; i++) begin
            cnt_next[i] = cnt_reg[i];
            if (cmd.finish) begin
                cnt_next[i] = '0;
            end else if (cmd.accept && cls_new == KW'(i)
                         && cnt_reg[i] != hsvct_pkg::CNT_MAX) begin
                cnt_next[i] = cnt_reg[i] + CW'(1);
            end
        end
        pix_next = pix_reg;
        if (cmd.finish) begin
            pix_next = '0;
        end else if (cmd.accept && pix_reg != hsvct_pkg::CNT_MAX) begin
            pix_next = pix_reg + CW'(1);
        end
        cls_next = cmd.accept ? cls_new : cls_reg;
    end

    // Dominant class scan, one counter per cycle; strict compare keeps lowest index
    assign cur_cnt = cnt_reg[idx_reg];

    always_comb begin
        idx_next  = idx_reg;
        best_next = best_reg;
        dom_next  = dom_reg;
        if (cmd.accept) begin
            idx_next  = '0;
            best_next = '0;
            dom_next  = hsvct_pkg::CLS_BLACK;
        end else if (cmd.search_en) begin
            idx_next = idx_reg + KW'(1);
            if (cur_cnt > best_reg) begin
                best_next = cur_cnt;
                dom_next  = idx_reg;
            end
        end
    end

    // Percent: multiply once, then one quotient bit per cycle, MSB first
    assign fits = rem_reg >= dvs_reg;

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        if (cmd.mult_en) begin
            rem_next  = PW'(best_reg) * PW'(hsvct_pkg::PCT_SCALE);
            dvs_next  = PW'(pix_reg) << (QW - 1);
            quo_next  = '0;
            step_next = SW'(QW - 1);
        end else if (cmd.div_en) begin
            if (fits) begin
                rem_next = rem_reg - dvs_reg;
            end
            dvs_next  = dvs_reg >> 1;
            quo_next  = {quo_reg[QW-2:0], fits};
            step_next = step_reg - SW'(1);
        end
    end

    // Two-deep result buffer: result stage feeding the output register
    assign res_move = res_valid_reg && (!out_valid_reg || m_ready);
    assign push     = (cmd.accept && !s_data.end_of_frame) || cmd.finish;

    always_comb begin
        res_next = res_reg;
        if (cmd.finish) begin
            res_next.color_class    = cls_reg;
            res_next.frame_done     = 1'b1;
            res_next.dominant_class = dom_reg;
            res_next.confidence_pct = quo_reg;
        end else if (cmd.accept) begin
            res_next.color_class    = cls_new;
            res_next.frame_done     = 1'b0;
            res_next.dominant_class = hsvct_pkg::CLS_BLACK;
            res_next.confidence_pct = '0;
        end

        if (push) begin
            res_valid_next = 1'b1;
        end else if (res_move) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end

        out_next = res_move ? res_reg : out_reg;
        if (res_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Status back to the controller
    assign st.res_free    = !res_valid_reg || res_move;
    assign st.search_last = idx_reg == hsvct_pkg::CLS_LAST;
    assign st.div_last    = step_reg == '0;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Control and counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < hsvct_pkg::NUM_CLASSES; i++) begin
                cnt_reg[i] <= '0;
            end
            pix_reg       <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '0;
        end else begin
            for (int i = 0; i < hsvct_pkg::NUM_CLASSES; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
            pix_reg       <= pix_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cls_reg  <= cls_next;
        best_reg <= best_next;
        dom_reg  <= dom_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/hsv_color_class_tally.sv =====
// HSV color class tally, top level: one result beat per pixel beat.
// Depends on hsvct_pkg, hsvct_ctrl and hsvct_datapath.
//
// Usage:
//   s_valid/s_ready/s_data carry one HSV pixel per beat, end_of_frame marking
//   the last pixel of a frame. m_valid/m_ready/m_data return one beat per
//   pixel: its color class, and on the end-of-frame pixel also the dominant
//   class of the frame and its share in percent (rounded down).
// Result path: a result passes through the result register and then the
//   output register; the end-of-frame result comes behind the report sequence.
// Throughput: ordinary pixels go at one per cycle while the result buffer has
//   room. An end-of-frame pixel holds s_ready low for the scan over the class
//   counters (one counter per cycle), the multiply by 100, the restoring
//   divider (one quotient bit per cycle) and the step that posts the report and
//   clears the counters.
// Reset (aresetn low, synchronous): counters cleared, result buffer empty,
//   controller idle.
// Stalls: a two-deep result buffer lets one more pixel in while a result
//   waits; once both are full s_ready drops until m_ready takes a beat.
`default_nettype none

module hsv_color_class_tally (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire hsvct_pkg::pixel_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output hsvct_pkg::result_t      m_data
);

    hsvct_pkg::cmd_t    cmd;
    hsvct_pkg::status_t st;

    // Frame sequencer
    hsvct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_eof   (s_data.end_of_frame),
        .st      (st),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    // Counters, divider and result buffer
    hsvct_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_ready (m_ready),
        .st      (st),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/hsvct_checker.sv =====
// Port-level checks for hsv_color_class_tally, attached by bind.
// Depends on hsvct_pkg.
`default_nettype none

module hsvct_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire hsvct_pkg::pixel_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire hsvct_pkg::result_t m_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed under stall");

    // Class codes stay in range
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.color_class <= hsvct_pkg::CLS_LAST
                 && m_data.dominant_class <= hsvct_pkg::CLS_LAST)
        else $error("class code out of range");

    // Frame fields are zero on ordinary pixels
    a_plain_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.frame_done
        |-> m_data.dominant_class == hsvct_pkg::CLS_BLACK && m_data.confidence_pct == '0)
        else $error("frame fields set on ordinary pixel");

    // Confidence never exceeds 100 percent
    a_conf_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_done |-> m_data.confidence_pct <= hsvct_pkg::PCT_SCALE)
        else $error("confidence above 100");

    // The frame report takes time: no pixel right after end of frame
    a_eof_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.end_of_frame |=> !s_ready)
        else $error("pixel taken during frame report");

endmodule

bind hsv_color_class_tally hsvct_checker u_hsvct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
